FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property checked at every rising clock edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// An implication checked with its consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/ttdc_pkg.sv
package ttdc_pkg;

   localparam int MAX_CELLS = 2048;
   localparam int ADDR_W    = $clog2(MAX_CELLS);
   localparam int CNT_W     = ADDR_W + 1;

   localparam logic [2:0] CMD_WRITE_CHAR = 3'd0;
   localparam logic [2:0] CMD_SET_POS    = 3'd1;
   localparam logic [2:0] CMD_CLEAR      = 3'd2;
   localparam logic [2:0] CMD_DRAW_NEXT  = 3'd3;
   localparam logic [2:0] CMD_REFRESH    = 3'd4;

   localparam logic [0:0] REG_SCREEN_COLS = 1'd0;
   localparam logic [0:0] REG_SCREEN_ROWS = 1'd1;

   localparam logic [7:0] CHAR_NEWLINE = 8'd10;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_FIRST   = 8'd32;
   localparam logic [7:0] ROW_MAX      = 8'hFF;

   localparam logic [7:0] COLS_RESET = 8'd80;
   localparam logic [7:0] ROWS_RESET = 8'd25;

endpackage

FILE: hw/rtl/ttdc_ram.sv
module ttdc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048,
   localparam int AddrW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AddrW-1:0] waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AddrW-1:0] raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: hw/rtl/text_terminal_dirty_cells_core.sv
// Character text screen with a changed-cell map.
// The req channel takes one command per beat (write_char, set_pos, clear,
// draw_next, refresh); every command gives exactly one beat on the rsp
// channel with the draw fields, the pending flag and the cursor after it.
// The csr port writes screen_cols (index 0) and screen_rows (index 1);
// write it only while the block is idle.
// After accept, set_pos, control codes, draw_next with pending clear and
// unused commands go from S_EXEC to S_DONE; a printable character passes
// S_EXEC, S_WC_CHK, S_WC_RD and S_WC_WR, with S_SC_RS, S_SC_RD and S_SC_WR
// run per active cell first when it scrolls the screen. Clear and refresh
// run S_FILL per active cell. Draw_next with pending set runs S_DR_RD and
// S_DR_CHK per cell scanned and S_DR_CH for the delivered cell.
// One item is in work at a time; the single cell and map RAM ports set
// the pace. The response register lets a new beat be accepted while
// the previous response waits under rsp_stall; a finished item then waits
// until that register is free.
// After reset the block sweeps both RAMs, setting every cell to a space
// and every changed bit, with req_stall high.
`include "assert_macros.svh"

module text_terminal_dirty_cells_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_cmd,
   input  logic [7:0]  req_char_code,
   input  logic [7:0]  req_pos_col,
   input  logic [7:0]  req_pos_row,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_draw_valid,
   output logic [10:0] rsp_draw_addr,
   output logic [7:0]  rsp_draw_char,
   output logic        rsp_pending,
   output logic [7:0]  rsp_cursor_col,
   output logic [7:0]  rsp_cursor_row,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [7:0]  csr_wdata
);
   import ttdc_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_INIT   = 4'd1;
   localparam logic [3:0] S_EXEC   = 4'd2;
   localparam logic [3:0] S_WC_CHK = 4'd3;
   localparam logic [3:0] S_WC_RD  = 4'd4;
   localparam logic [3:0] S_WC_WR  = 4'd5;
   localparam logic [3:0] S_SC_RS  = 4'd6;
   localparam logic [3:0] S_SC_RD  = 4'd7;
   localparam logic [3:0] S_SC_WR  = 4'd8;
   localparam logic [3:0] S_FILL   = 4'd9;
   localparam logic [3:0] S_DR_RD  = 4'd10;
   localparam logic [3:0] S_DR_CHK = 4'd11;
   localparam logic [3:0] S_DR_CH  = 4'd12;
   localparam logic [3:0] S_DONE   = 4'd13;

   logic [3:0]       state_ff, state_in;
   logic [7:0]       cols_ff, rows_ff;
   logic [7:0]       cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic             dirty_ff, dirty_in;
   logic [2:0]       cmd_ff, cmd_in;
   logic [7:0]       ch_ff, ch_in, pcol_ff, pcol_in, prow_ff, prow_in;
   logic [CNT_W-1:0] ptr_ff, ptr_in;
   logic [16:0]      tgt_ff, tgt_in;
   logic [7:0]       src_ff, src_in;
   logic             src_ok_ff, src_ok_in;
   logic             found_ff, found_in;
   logic             dv_ff, dv_in;
   logic [10:0]      da_ff, da_in;
   logic [7:0]       dc_ff, dc_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_dv_ff, rsp_dv_in;
   logic [10:0]      rsp_da_ff, rsp_da_in;
   logic [7:0]       rsp_dc_ff, rsp_dc_in;
   logic             rsp_pend_ff, rsp_pend_in;
   logic [7:0]       rsp_col_ff, rsp_col_in, rsp_row_ff, rsp_row_in;

   logic [7:0]        cols_eff, rows_eff, y_inc;
   logic [15:0]       prod;
   logic [CNT_W-1:0]  n_active;
   logic [CNT_W:0]    src_addr;
   logic              accept, rsp_free;

   logic              cell_we, bit_we, bit_wdata, bit_rdata;
   logic [ADDR_W-1:0] cell_waddr, cell_raddr, bit_waddr, bit_raddr;
   logic [7:0]        cell_wdata, cell_rdata;

   ttdc_ram #(.WIDTH(8), .DEPTH(MAX_CELLS)) u_cells (
      .clock(clock), .we(cell_we), .waddr(cell_waddr), .wdata(cell_wdata),
      .raddr(cell_raddr), .rdata(cell_rdata)
   );

   ttdc_ram #(.WIDTH(1), .DEPTH(MAX_CELLS)) u_map (
      .clock(clock), .we(bit_we), .waddr(bit_waddr), .wdata(bit_wdata),
      .raddr(bit_raddr), .rdata(bit_rdata)
   );

   assign cols_eff = (cols_ff == 8'd0) ? 8'd1 : cols_ff;
   assign rows_eff = (rows_ff == 8'd0) ? 8'd1 : rows_ff;
   assign prod     = cols_eff * rows_eff;
   assign n_active = (prod > 16'(MAX_CELLS)) ? CNT_W'(MAX_CELLS) : prod[CNT_W-1:0];
   assign y_inc    = (cur_y_ff == ROW_MAX) ? ROW_MAX : cur_y_ff + 8'd1;
   assign src_addr = {1'b0, ptr_ff} + {{(CNT_W - 7){1'b0}}, cols_eff};

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      dirty_in     = dirty_ff;
      cmd_in       = cmd_ff;
      ch_in        = ch_ff;
      pcol_in      = pcol_ff;
      prow_in      = prow_ff;
      ptr_in       = ptr_ff;
      tgt_in       = tgt_ff;
      src_in       = src_ff;
      src_ok_in    = src_ok_ff;
      found_in     = found_ff;
      dv_in        = dv_ff;
      da_in        = da_ff;
      dc_in        = dc_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_dv_in    = rsp_dv_ff;
      rsp_da_in    = rsp_da_ff;
      rsp_dc_in    = rsp_dc_ff;
      rsp_pend_in  = rsp_pend_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      cell_we      = 1'b0;
      cell_waddr   = ptr_ff[ADDR_W-1:0];
      cell_wdata   = CHAR_SPACE;
      cell_raddr   = ptr_ff[ADDR_W-1:0];
      bit_we       = 1'b0;
      bit_waddr    = ptr_ff[ADDR_W-1:0];
      bit_wdata    = 1'b1;
      bit_raddr    = ptr_ff[ADDR_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in   = req_cmd;
               ch_in    = req_char_code;
               pcol_in  = req_pos_col;
               prow_in  = req_pos_row;
               state_in = S_EXEC;
            end
         end
         S_INIT: begin
            cell_we  = 1'b1;
            bit_we   = 1'b1;
            ptr_in   = ptr_ff + 1'b1;
            if (ptr_ff == CNT_W'(MAX_CELLS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_EXEC: begin
            dv_in    = 1'b0;
            da_in    = '0;
            dc_in    = '0;
            ptr_in   = '0;
            found_in = 1'b0;
            state_in = S_DONE;
            case (cmd_ff)
               CMD_WRITE_CHAR: begin
                  if (ch_ff == CHAR_NEWLINE) begin
                     cur_x_in = 8'd0;
                     cur_y_in = y_inc;
                  end else if (ch_ff >= CHAR_FIRST) begin
                     if (cur_x_ff >= cols_eff) begin
                        cur_x_in = 8'd0;
                        cur_y_in = y_inc;
                     end
                     state_in = S_WC_CHK;
                  end
               end
               CMD_SET_POS: begin
                  cur_x_in = pcol_ff;
                  cur_y_in = prow_ff;
               end
               CMD_CLEAR, CMD_REFRESH: state_in = S_FILL;
               CMD_DRAW_NEXT: begin
                  if (dirty_ff) begin
                     state_in = S_DR_RD;
                  end
               end
               default: state_in = S_DONE;
            endcase
         end
         S_WC_CHK: begin
            state_in = (cur_y_ff >= rows_eff) ? S_SC_RS : S_WC_RD;
         end
         S_WC_RD: begin
            tgt_in     = {1'b0, {8'd0, cur_y_ff} * {8'd0, cols_eff}} + {9'd0, cur_x_ff};
            cell_raddr = tgt_in[ADDR_W-1:0];
            state_in   = S_WC_WR;
         end
         S_WC_WR: begin
            cell_waddr = tgt_ff[ADDR_W-1:0];
            bit_waddr  = tgt_ff[ADDR_W-1:0];
            cell_wdata = ch_ff;
            if ((tgt_ff < 17'(n_active)) && (cell_rdata != ch_ff)) begin
               cell_we  = 1'b1;
               bit_we   = 1'b1;
               dirty_in = 1'b1;
            end
            cur_x_in = cur_x_ff + 8'd1;
            state_in = S_DONE;
         end
         S_SC_RS: begin
            if (ptr_ff >= n_active) begin
               cur_y_in = rows_eff - 8'd1;
               cur_x_in = 8'd0;
               state_in = S_WC_RD;
            end else begin
               cell_raddr = src_addr[ADDR_W-1:0];
               src_ok_in  = (src_addr < (CNT_W + 1)'(n_active));
               state_in   = S_SC_RD;
            end
         end
         S_SC_RD: begin
            src_in   = src_ok_ff ? cell_rdata : CHAR_SPACE;
            state_in = S_SC_WR;
         end
         S_SC_WR: begin
            cell_wdata = src_ff;
            if (cell_rdata != src_ff) begin
               cell_we  = 1'b1;
               bit_we   = 1'b1;
               dirty_in = 1'b1;
            end
            ptr_in   = ptr_ff + 1'b1;
            state_in = S_SC_RS;
         end
         S_FILL: begin
            if (ptr_ff >= n_active) begin
               dirty_in = 1'b1;
               if (cmd_ff == CMD_CLEAR) begin
                  cur_x_in = 8'd0;
                  cur_y_in = 8'd0;
               end
               state_in = S_DONE;
            end else begin
               bit_we  = 1'b1;
               cell_we = (cmd_ff == CMD_CLEAR);
               ptr_in  = ptr_ff + 1'b1;
            end
         end
         S_DR_RD: begin
            if (ptr_ff >= n_active) begin
               dirty_in = 1'b0;
               state_in = S_DONE;
            end else begin
               state_in = S_DR_CHK;
            end
         end
         S_DR_CHK: begin
            if (bit_rdata) begin
               if (found_ff) begin
                  state_in = S_DONE;
               end else begin
                  found_in  = 1'b1;
                  dv_in     = 1'b1;
                  da_in     = ptr_ff[ADDR_W-1:0];
                  bit_we    = 1'b1;
                  bit_wdata = 1'b0;
                  state_in  = S_DR_CH;
               end
            end else begin
               ptr_in   = ptr_ff + 1'b1;
               state_in = S_DR_RD;
            end
         end
         S_DR_CH: begin
            dc_in    = cell_rdata;
            ptr_in   = ptr_ff + 1'b1;
            state_in = S_DR_RD;
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_dv_in    = dv_ff;
               rsp_da_in    = da_ff;
               rsp_dc_in    = dc_ff;
               rsp_pend_in  = dirty_ff;
               rsp_col_in   = cur_x_ff;
               rsp_row_in   = cur_y_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         cols_ff      <= COLS_RESET;
         rows_ff      <= ROWS_RESET;
         cur_x_ff     <= 8'd0;
         cur_y_ff     <= 8'd0;
         dirty_ff     <= 1'b1;
         ptr_ff       <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         dirty_ff     <= dirty_in;
         ptr_ff       <= ptr_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               REG_SCREEN_COLS: cols_ff <= csr_wdata;
               REG_SCREEN_ROWS: rows_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      ch_ff       <= ch_in;
      pcol_ff     <= pcol_in;
      prow_ff     <= prow_in;
      tgt_ff      <= tgt_in;
      src_ff      <= src_in;
      src_ok_ff   <= src_ok_in;
      dv_ff       <= dv_in;
      da_ff       <= da_in;
      dc_ff       <= dc_in;
      rsp_dv_ff   <= rsp_dv_in;
      rsp_da_ff   <= rsp_da_in;
      rsp_dc_ff   <= rsp_dc_in;
      rsp_pend_ff <= rsp_pend_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_row_ff  <= rsp_row_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_draw_valid = rsp_dv_ff;
   assign rsp_draw_addr  = rsp_da_ff;
   assign rsp_draw_char  = rsp_dc_ff;
   assign rsp_pending    = rsp_pend_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cursor_row = rsp_row_ff;

   `ASSERT_CLK(a_rsp_from_done, $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE), "stray rsp")
   `ASSERT_CLK(a_map_set_with_cell, (cell_we && bit_we) |-> bit_wdata, "bit cleared")
   `ASSERT_NEXT(a_accept_exec, accept, state_ff == S_EXEC, "accepted beat not executed")

endmodule
